// ===== src/mfps_pkg.sv =====
// Shared types and constants for the maximum falling path sum block.
// No dependencies; imported by every module of the block except mfps_ram.
package mfps_pkg;

    localparam int VALUE_W     = 16;           // matrix element width
    localparam int SUM_W       = 48;           // path sum width
    localparam int CFG_W       = 9;            // num_cols register width
    localparam int QUEUE_DEPTH = 4;            // front-to-back queue entries
    localparam int QPTR_W      = 2;            // log2 of QUEUE_DEPTH

    localparam logic [CFG_W-1:0] NUM_COLS_RESET = 9'd256;

    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

    // Classification the front attaches to each element.
    typedef struct packed {
        logic first_row;   // element belongs to the first row
        logic col_is0;     // column 0
        logic col_is1;     // column 1
        logic col_is2;     // column 2
        logic has_right;   // right neighbor exists (not row end)
        logic final_cell;  // last element of the matrix
    } t_flags;

endpackage

// ===== src/mfps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mfps_front.sv =====
// Front end: accepts elements, tracks column and first-row status, tags each element.
// Depends on mfps_pkg.
module mfps_front
    import mfps_pkg::*;
#(
    parameter int MAX_COLS = 256,
    localparam int AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CFG_W-1:0]   i_num_cols,
    input  logic               i_accept,
    input  logic               i_final_cell,
    output t_flags             o_flags,
    output logic [AW-1:0]      o_col
);

    localparam int CMPW = (AW + 1 > CFG_W + 1) ? AW + 1 : CFG_W + 1;

    logic [AW-1:0]   r_col;
    logic [AW-1:0]   n_col;
    logic            r_first;
    logic            n_first;
    logic [CMPW-1:0] eff_cols;
    logic [CMPW-1:0] col_w;
    logic            row_end;

    // Zero columns acts as one; counts above the store depth clamp to it.
    always_comb begin
        if (i_num_cols == '0) begin
            eff_cols = CMPW'(1);
        end else if (CMPW'(i_num_cols) > CMPW'(MAX_COLS)) begin
            eff_cols = CMPW'(MAX_COLS);
        end else begin
            eff_cols = CMPW'(i_num_cols);
        end
    end

    assign col_w   = CMPW'(r_col);
    assign row_end = (col_w + CMPW'(1)) >= eff_cols;

    always_comb begin
        o_flags.first_row  = r_first;
        o_flags.col_is0    = (col_w == CMPW'(0));
        o_flags.col_is1    = (col_w == CMPW'(1));
        o_flags.col_is2    = (col_w == CMPW'(2));
        o_flags.has_right  = !row_end;
        o_flags.final_cell = i_final_cell;
        o_col              = r_col;
    end

    always_comb begin
        n_col   = r_col;
        n_first = r_first;
        if (i_accept) begin
            if (i_final_cell) begin
                n_col   = '0;
                n_first = 1'b1;
            end else if (row_end) begin
                n_col   = '0;
                n_first = 1'b0;
            end else begin
                n_col   = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
        end else begin
            r_col   <= n_col;
            r_first <= n_first;
        end
    end

endmodule

// ===== src/mfps_queue.sv =====
// Short register FIFO between front and back ends.
// Depends on mfps_pkg for the queue depth.
module mfps_queue
    import mfps_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]  r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/mfps_back.sv =====
// Back end: neighbor max, saturating add, row store update, row maximum and result register.
// Depends on mfps_pkg and mfps_ram.
module mfps_back
    import mfps_pkg::*;
#(
    parameter int MAX_COLS = 256,
    localparam int AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  t_flags                    i_q_flags,
    input  logic [AW-1:0]             i_q_col,
    input  logic signed [VALUE_W-1:0] i_q_value,
    output logic                      o_q_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [SUM_W-1:0]   o_best_sum
);

    // Operand window: previous-row sums at j-1, j and j+1.
    logic signed [SUM_W-1:0]   r_left;
    logic signed [SUM_W-1:0]   r_a;
    logic signed [SUM_W-1:0]   r_head0;     // mirror of store entry 0
    logic signed [SUM_W-1:0]   r_head1;     // mirror of store entry 1
    logic signed [SUM_W-1:0]   ram_rdata;

    // Execute stage
    logic                      r_y_valid;
    t_flags                    r_y_flags;
    logic [AW-1:0]             r_y_col;
    logic signed [VALUE_W-1:0] r_y_value;
    logic signed [SUM_W-1:0]   r_y_best;
    logic signed [SUM_W-1:0]   r_row_best;

    logic                      r_out_valid;
    logic signed [SUM_W-1:0]   r_out_value;

    logic signed [SUM_W-1:0]   a_eff;
    logic signed [SUM_W-1:0]   b_eff;
    logic signed [SUM_W-1:0]   best;
    logic                      hazard;
    logic                      fire;
    logic                      out_free;
    logic                      y_done;
    logic [AW:0]               col_plus2;
    logic signed [SUM_W:0]     wide_sum;
    logic signed [SUM_W-1:0]   sat_sum;
    logic signed [SUM_W-1:0]   y_sum;
    logic signed [SUM_W-1:0]   row_best_new;

    // Neighbor selection; row start takes its operands from the head mirrors.
    always_comb begin
        a_eff = i_q_flags.col_is0 ? r_head0 : r_a;
        b_eff = i_q_flags.col_is0 ? r_head1 : ram_rdata;
        best  = a_eff;
        if (!i_q_flags.col_is0 && (r_left > best)) begin
            best = r_left;
        end
        if (i_q_flags.has_right && (b_eff > best)) begin
            best = b_eff;
        end
    end

    // Row start must wait while columns 0..2 are still being written.
    assign hazard   = !i_q_flags.first_row && i_q_flags.col_is0 && r_y_valid &&
                      (r_y_flags.col_is0 || r_y_flags.col_is1 || r_y_flags.col_is2);
    assign out_free = !r_out_valid || !i_out_stall;
    assign y_done   = r_y_valid && (!r_y_flags.final_cell || out_free);
    assign fire     = i_q_valid && (!r_y_valid || y_done) && !hazard;
    assign o_q_pop  = fire;

    assign col_plus2 = {1'b0, i_q_col} + (AW + 1)'(2);

    always_comb begin
        wide_sum = {r_y_best[SUM_W-1], r_y_best} +
                   {{(SUM_W + 1 - VALUE_W){r_y_value[VALUE_W-1]}}, r_y_value};
        if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
            sat_sum = wide_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sat_sum = wide_sum[SUM_W-1:0];
        end
        y_sum = r_y_flags.first_row ?
                {{(SUM_W - VALUE_W){r_y_value[VALUE_W-1]}}, r_y_value} : sat_sum;
        row_best_new = (r_y_flags.col_is0 || (y_sum > r_row_best)) ? y_sum : r_row_best;
    end

    mfps_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLS)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (y_done),
        .i_waddr (r_y_col),
        .i_wdata (y_sum),
        .i_re    (fire),
        .i_raddr (col_plus2[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_left    <= a_eff;
            r_a       <= b_eff;
            r_y_flags <= i_q_flags;
            r_y_col   <= i_q_col;
            r_y_value <= i_q_value;
            r_y_best  <= best;
        end
        if (y_done && r_y_flags.col_is0) begin
            r_head0 <= y_sum;
        end
        if (y_done && r_y_flags.col_is1) begin
            r_head1 <= y_sum;
        end
        if (y_done && r_y_flags.final_cell) begin
            r_out_value <= row_best_new;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_best  <= SUM_MIN;
        end else begin
            if (fire) begin
                r_y_valid <= 1'b1;
            end else if (y_done) begin
                r_y_valid <= 1'b0;
            end
            if (y_done) begin
                r_row_best <= r_y_flags.final_cell ? SUM_MIN : row_best_new;
            end
            if (y_done && r_y_flags.final_cell) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_best_sum  = r_out_value;

endmodule

// ===== src/max_falling_path_sum.sv =====
// Top level of the streaming maximum falling path sum block.
// Depends on mfps_pkg, mfps_front, mfps_queue, mfps_back (and mfps_ram below it).
//
// Matrix elements stream in row-major order, one signed 16-bit value per
// transfer, with i_final_cell set on the last element. Each element's path
// sum is its value plus the largest previous-row sum among its own column
// and its left and right neighbors (first row: the value alone), saturated
// to signed 48 bits. On the flagged element one result transfer carries the
// largest sum of that row. Rate: one element per clock cycle sustained while
// results are taken; the first element of a row waits when rows are three
// columns or narrower, since it needs store entries 0..2 that the previous
// element is still writing. With nothing stalled, the result passes the queue
// entry, the neighbor-max register and the result register before it is
// valid. The previous row lives in one MAX_COLS x 48 RAM (one write, one
// registered read per cycle); entries 0 and 1 are mirrored in registers so a
// row start needs no second read port. The store needs no clearing after
// reset. num_cols may be written only while the block is idle; 0 acts as 1
// and values above MAX_COLS clamp. A four-entry queue parts the front (column
// tracking) from the back (arithmetic), and the result register lets input
// keep flowing while a result waits to be taken.
module max_falling_path_sum
    import mfps_pkg::*;
#(
    parameter int MAX_COLS = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_num_cols_we,
    input  logic [CFG_W-1:0]          i_num_cols,
    // element input
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [VALUE_W-1:0] i_cell_value,
    input  logic                      i_final_cell,
    // result output
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [SUM_W-1:0]   o_best_sum
);

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int QW = $bits(t_flags) + AW + VALUE_W;

    logic [CFG_W-1:0]          r_num_cols;
    logic                      in_xfer;
    t_flags                    front_flags;
    logic [AW-1:0]             front_col;
    logic                      q_full;
    logic                      q_valid;
    logic                      q_pop;
    logic [QW-1:0]             q_wdata;
    logic [QW-1:0]             q_rdata;
    t_flags                    q_flags;
    logic [AW-1:0]             q_col;
    logic signed [VALUE_W-1:0] q_value;

    // Column count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= NUM_COLS_RESET;
        end else if (i_num_cols_we) begin
            r_num_cols <= i_num_cols;
        end
    end

    assign o_in_stall = q_full;
    assign in_xfer    = i_in_valid && !q_full;

    mfps_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_num_cols   (r_num_cols),
        .i_accept     (in_xfer),
        .i_final_cell (i_final_cell),
        .o_flags      (front_flags),
        .o_col        (front_col)
    );

    assign q_wdata = {front_flags, front_col, i_cell_value};

    mfps_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign {q_flags, q_col, q_value} = q_rdata;

    mfps_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_flags   (q_flags),
        .i_q_col     (q_col),
        .i_q_value   (q_value),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_best_sum  (o_best_sum)
    );

endmodule
